[rtl/core/i2cte_pkg.sv]
package i2cte_pkg;

   localparam int STORE_DEPTH = 32;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   localparam logic [6:0] OWN_ADDRESS_RESET = 7'd40;
   localparam int PORT_MSG_LEN = 3;
   localparam int PORT_COUNT = 4;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_ADDRESSED = 3'd0;
   localparam kind_type KIND_READ      = 3'd1;
   localparam kind_type KIND_WRITE     = 3'd2;
   localparam kind_type KIND_STOP      = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     item_taken;
      kind_type kind;
      logic     read_hit;
      logic     port_candidate;
      logic     last_fetch;
      logic     out_free;
   } status_type;

   typedef struct packed {
      logic in_ready;
      logic exec;
      logic fetch;
      logic load_out;
   } ctrl_type;

endpackage

[rtl/core/i2c_target_echo_and_port_writer.sv]
// Each item goes through the sequencer states EXEC, then FETCH for a master read that finds
// data or a stop that may complete a port write, then FINISH, where the result is loaded
// into the output register once that is free; only then is a new item taken. FETCH uses
// the single read port of the byte stores, which the sequencer walks one byte a cycle.
// Reset clears the sequencer, the counts and the output valid flag and sets own_address to 40;
// the two byte stores are not cleared, and are never read beyond their fill counts.
module i2c_target_echo_and_port_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [6:0]  req_bus_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ack,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_port_write,
   output logic [1:0]  rsp_port_index,
   output logic [15:0] rsp_port_value,
   output logic        rsp_echo_captured,
   output logic [5:0]  rsp_echo_length,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);

   localparam int AW = i2cte_pkg::ADDR_W;
   localparam int CW = i2cte_pkg::CNT_W;

   i2cte_pkg::status_type status;
   i2cte_pkg::ctrl_type   ctrl;

   logic [6:0]           own_addr_ff;
   i2cte_pkg::kind_type  kind_ff, kind_in;
   logic [6:0]           bus_addr_ff, bus_addr_in;
   logic [7:0]           wdata_ff, wdata_in;
   logic [CW-1:0]        rx_cnt_ff, rx_cnt_in;
   logic [CW-1:0]        tx_cnt_ff, tx_cnt_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic                 bank_ff, bank_in;
   logic [1:0]           step_ff, step_in;

   logic                 w_ack_ff, w_ack_in;
   logic                 w_rvalid_ff, w_rvalid_in;
   logic [7:0]           w_rdata_ff, w_rdata_in;
   logic                 w_pwrite_ff, w_pwrite_in;
   logic [1:0]           w_pindex_ff, w_pindex_in;
   logic [15:0]          w_pvalue_ff, w_pvalue_in;
   logic                 w_echo_ff, w_echo_in;
   logic [5:0]           w_elen_ff, w_elen_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 o_ack_ff;
   logic                 o_rvalid_ff;
   logic [7:0]           o_rdata_ff;
   logic                 o_pwrite_ff;
   logic [1:0]           o_pindex_ff;
   logic [15:0]          o_pvalue_ff;
   logic                 o_echo_ff;
   logic [5:0]           o_elen_ff;

   logic                 item_taken;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;
   logic                 rd_bank;
   logic [7:0]           rd_data0, rd_data1, rd_data;

   assign item_taken = req_valid && req_ready;
   assign req_ready  = ctrl.in_ready;

   assign status.item_taken     = item_taken;
   assign status.kind           = kind_ff;
   assign status.read_hit       = pos_ff < tx_cnt_ff;
   assign status.port_candidate = (tx_cnt_ff == '0) &&
                                  (rx_cnt_ff == CW'(i2cte_pkg::PORT_MSG_LEN));
   assign status.last_fetch     = (kind_ff == i2cte_pkg::KIND_READ) || (step_ff == 2'd2);
   assign status.out_free       = !rsp_valid_ff || rsp_ready;

   i2cte_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Bank bank_ff holds the bytes being received; the other bank holds the echo bytes.
   assign wr_en   = ctrl.exec && (kind_ff == i2cte_pkg::KIND_WRITE) &&
                    (rx_cnt_ff < CW'(i2cte_pkg::STORE_DEPTH));
   assign rd_bank = (kind_ff == i2cte_pkg::KIND_READ) ? ~bank_ff : bank_ff;
   assign rd_data = rd_bank ? rd_data1 : rd_data0;

   always_comb begin
      if (ctrl.exec) begin
         rd_addr = (kind_ff == i2cte_pkg::KIND_READ) ? pos_ff[AW-1:0] : '0;
      end else begin
         rd_addr = AW'({1'b0, step_ff} + 3'd1);
      end
   end

   i2cte_ram #(.WIDTH(8), .DEPTH(i2cte_pkg::STORE_DEPTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_ff),
      .wr_addr (rx_cnt_ff[AW-1:0]),
      .wr_data (wdata_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   i2cte_ram #(.WIDTH(8), .DEPTH(i2cte_pkg::STORE_DEPTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && bank_ff),
      .wr_addr (rx_cnt_ff[AW-1:0]),
      .wr_data (wdata_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   always_comb begin
      kind_in     = kind_ff;
      bus_addr_in = bus_addr_ff;
      wdata_in    = wdata_ff;
      rx_cnt_in   = rx_cnt_ff;
      tx_cnt_in   = tx_cnt_ff;
      pos_in      = pos_ff;
      bank_in     = bank_ff;
      step_in     = step_ff;
      w_ack_in    = w_ack_ff;
      w_rvalid_in = w_rvalid_ff;
      w_rdata_in  = w_rdata_ff;
      w_pwrite_in = w_pwrite_ff;
      w_pindex_in = w_pindex_ff;
      w_pvalue_in = w_pvalue_ff;
      w_echo_in   = w_echo_ff;
      w_elen_in   = w_elen_ff;

      if (item_taken) begin
         kind_in     = req_kind;
         bus_addr_in = req_bus_address;
         wdata_in    = req_write_data;
      end

      if (ctrl.exec) begin
         w_ack_in    = 1'b0;
         w_rvalid_in = 1'b0;
         w_rdata_in  = 8'hFF;
         w_pwrite_in = 1'b0;
         w_pindex_in = 2'd0;
         w_pvalue_in = 16'd0;
         w_echo_in   = 1'b0;
         w_elen_in   = 6'd0;
         step_in     = 2'd0;
         case (kind_ff)
            i2cte_pkg::KIND_ADDRESSED: begin
               w_ack_in = (bus_addr_ff == own_addr_ff);
               // Pending write bytes become the echo bytes by swapping the banks.
               if (rx_cnt_ff != '0) begin
                  bank_in   = ~bank_ff;
                  tx_cnt_in = rx_cnt_ff;
                  rx_cnt_in = '0;
                  pos_in    = '0;
               end
            end
            i2cte_pkg::KIND_READ: begin
               w_ack_in = 1'b1;
               if (status.read_hit) begin
                  pos_in = pos_ff + CW'(1);
               end
            end
            i2cte_pkg::KIND_WRITE: begin
               if (wr_en) begin
                  rx_cnt_in = rx_cnt_ff + CW'(1);
                  w_ack_in  = rx_cnt_ff < CW'(i2cte_pkg::STORE_DEPTH - 1);
               end
            end
            i2cte_pkg::KIND_STOP: begin
               w_ack_in = 1'b1;
               if (tx_cnt_ff != '0 && rx_cnt_ff == '0) begin
                  w_echo_in = 1'b1;
                  w_elen_in = 6'(tx_cnt_ff);
               end
               tx_cnt_in = '0;
               rx_cnt_in = '0;
            end
            default: begin
               w_ack_in = 1'b0;
            end
         endcase
      end

      if (ctrl.fetch) begin
         if (kind_ff == i2cte_pkg::KIND_READ) begin
            w_rvalid_in = 1'b1;
            w_rdata_in  = rd_data;
         end else begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: begin
                  w_pwrite_in = rd_data < 8'(i2cte_pkg::PORT_COUNT);
                  w_pindex_in = (rd_data < 8'(i2cte_pkg::PORT_COUNT)) ? rd_data[1:0] : 2'd0;
               end
               2'd1: begin
                  w_pvalue_in[15:8] = w_pwrite_ff ? rd_data : 8'd0;
               end
               default: begin
                  w_pvalue_in[7:0] = w_pwrite_ff ? rd_data : 8'd0;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff  <= i2cte_pkg::OWN_ADDRESS_RESET;
         rx_cnt_ff    <= '0;
         tx_cnt_ff    <= '0;
         pos_ff       <= '0;
         bank_ff      <= 1'b0;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            own_addr_ff <= csr_write_data;
         end
         rx_cnt_ff    <= rx_cnt_in;
         tx_cnt_ff    <= tx_cnt_in;
         pos_ff       <= pos_in;
         bank_ff      <= bank_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      bus_addr_ff <= bus_addr_in;
      wdata_ff    <= wdata_in;
      w_ack_ff    <= w_ack_in;
      w_rvalid_ff <= w_rvalid_in;
      w_rdata_ff  <= w_rdata_in;
      w_pwrite_ff <= w_pwrite_in;
      w_pindex_ff <= w_pindex_in;
      w_pvalue_ff <= w_pvalue_in;
      w_echo_ff   <= w_echo_in;
      w_elen_ff   <= w_elen_in;
      if (ctrl.load_out) begin
         o_ack_ff    <= w_ack_ff;
         o_rvalid_ff <= w_rvalid_ff;
         o_rdata_ff  <= w_rdata_ff;
         o_pwrite_ff <= w_pwrite_ff;
         o_pindex_ff <= w_pindex_ff;
         o_pvalue_ff <= w_pvalue_ff;
         o_echo_ff   <= w_echo_ff;
         o_elen_ff   <= w_elen_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ack           = o_ack_ff;
   assign rsp_read_valid    = o_rvalid_ff;
   assign rsp_read_data     = o_rdata_ff;
   assign rsp_port_write    = o_pwrite_ff;
   assign rsp_port_index    = o_pindex_ff;
   assign rsp_port_value    = o_pvalue_ff;
   assign rsp_echo_captured = o_echo_ff;
   assign rsp_echo_length   = o_elen_ff;

`ifndef SYNTHESIS
   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      (rx_cnt_ff <= CW'(i2cte_pkg::STORE_DEPTH)) && (tx_cnt_ff <= CW'(i2cte_pkg::STORE_DEPTH)) &&
      (pos_ff <= tx_cnt_ff || tx_cnt_ff == '0))
      else $error("store count or read position out of range");
   a_idle_bus_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_read_valid) |-> (rsp_read_data == 8'hFF))
      else $error("read data not idle while no byte is supplied");
   a_one_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_port_write && rsp_echo_captured))
      else $error("port write and echo capture reported together");
   a_quiet_port: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_port_write) |-> (rsp_port_value == 16'd0 && rsp_port_index == 2'd0))
      else $error("port fields set without a port write");
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |=> rsp_valid)
      else $error("loaded result not presented");
`endif

endmodule

[rtl/core/i2cte_ram.sv]
module i2cte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/i2cte_seq.sv]
module i2cte_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cte_pkg::status_type  status,
   output i2cte_pkg::ctrl_type    ctrl
);

   i2cte_pkg::state_type state_ff;
   i2cte_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2cte_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2cte_pkg::ST_IDLE: begin
            if (status.item_taken) begin
               state_in = i2cte_pkg::ST_EXEC;
            end
         end
         i2cte_pkg::ST_EXEC: begin
            // A read that finds data and a possible port write both need the store.
            if ((status.kind == i2cte_pkg::KIND_READ && status.read_hit) ||
                (status.kind == i2cte_pkg::KIND_STOP && status.port_candidate)) begin
               state_in = i2cte_pkg::ST_FETCH;
            end else begin
               state_in = i2cte_pkg::ST_FINISH;
            end
         end
         i2cte_pkg::ST_FETCH: begin
            if (status.last_fetch) begin
               state_in = i2cte_pkg::ST_FINISH;
            end
         end
         i2cte_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = i2cte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = i2cte_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.in_ready = 1'b0;
      ctrl.exec     = 1'b0;
      ctrl.fetch    = 1'b0;
      ctrl.load_out = 1'b0;
      case (state_ff)
         i2cte_pkg::ST_IDLE:   ctrl.in_ready = 1'b1;
         i2cte_pkg::ST_EXEC:   ctrl.exec = 1'b1;
         i2cte_pkg::ST_FETCH:  ctrl.fetch = 1'b1;
         i2cte_pkg::ST_FINISH: ctrl.load_out = status.out_free;
         default: begin
            ctrl.in_ready = 1'b0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_fetch_only_for_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2cte_pkg::ST_FETCH) |->
      (status.kind == i2cte_pkg::KIND_READ || status.kind == i2cte_pkg::KIND_STOP))
      else $error("store fetch for an item that needs no store access");
   a_taken_goes_exec: assert property (@(posedge clock) disable iff (reset)
      (status.item_taken && ctrl.in_ready) |=> (state_ff == i2cte_pkg::ST_EXEC))
      else $error("accepted item did not start execution");
   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |=> ctrl.in_ready)
      else $error("sequencer did not return to idle after loading a result");
`endif

endmodule

[dv/i2c_reply_checker.sv]
module i2c_reply_checker
   import i2cte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [6:0]  req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_ack,
   input  logic        rsp_read_valid,
   input  logic [7:0]  rsp_read_data,
   input  logic        rsp_port_write,
   input  logic [1:0]  rsp_port_index,
   input  logic [15:0] rsp_port_value,
   input  logic        rsp_echo_captured,
   input  logic [5:0]  rsp_echo_length,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data,
   output int          mismatch_count,
   output int          replies_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        ack;
      logic        read_valid;
      logic [7:0]  read_data;
      logic        port_write;
      logic [1:0]  port_index;
      logic [15:0] port_value;
      logic        echo_captured;
      logic [5:0]  echo_length;
   } reply_type;

   logic [6:0] own_address;
   logic [7:0] rx_bytes [STORE_DEPTH];
   logic [7:0] tx_bytes [STORE_DEPTH];
   int         rx_fill;
   int         tx_fill;
   int         tx_next;
   reply_type  expected_replies [$];

   // Works out the reply to one bus event and moves the target's state on.
   function automatic reply_type predict_reply(kind_type kind, logic [6:0] addr,
                                               logic [7:0] data);
      reply_type r;
      int        i;
      r = '0;
      r.read_data = 8'hFF;
      case (kind)
         KIND_ADDRESSED: begin
            r.ack = (addr == own_address);
            // Bytes written earlier become the echo source, matched address or not.
            if (rx_fill != 0) begin
               for (i = 0; i < rx_fill; i++) tx_bytes[i] = rx_bytes[i];
               tx_fill = rx_fill;
               rx_fill = 0;
               tx_next = 0;
            end
         end
         KIND_READ: begin
            r.ack = 1'b1;
            if (tx_next < tx_fill) begin
               r.read_valid = 1'b1;
               r.read_data = tx_bytes[tx_next];
               tx_next++;
            end
         end
         KIND_WRITE: begin
            if (rx_fill < STORE_DEPTH) begin
               rx_bytes[rx_fill] = data;
               rx_fill++;
               r.ack = (rx_fill < STORE_DEPTH);
            end
         end
         KIND_STOP: begin
            r.ack = 1'b1;
            if (tx_fill != 0) begin
               if (rx_fill == 0) begin
                  r.echo_captured = 1'b1;
                  r.echo_length = 6'(tx_fill);
               end
            end else if (rx_fill == PORT_MSG_LEN && rx_bytes[0] < PORT_COUNT) begin
               r.port_write = 1'b1;
               r.port_index = rx_bytes[0][1:0];
               r.port_value = {rx_bytes[1], rx_bytes[2]};
            end
            tx_fill = 0;
            rx_fill = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_field(string field, int expected, int actual);
      if (expected != actual) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      reply_type seen;
      reply_type want;
      if (reset) begin
         own_address = OWN_ADDRESS_RESET;
         rx_fill = 0;
         tx_fill = 0;
         tx_next = 0;
         expected_replies.delete();
      end else begin
         if (csr_write_enable) own_address = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_ack, rsp_read_valid, rsp_read_data, rsp_port_write, rsp_port_index,
                    rsp_port_value, rsp_echo_captured, rsp_echo_length};
            if (expected_replies.size() == 0) begin
               $display("%0t: reply 0x%0h arrived with none outstanding", $time, seen);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               report_field("ack", want.ack, seen.ack);
               report_field("read_valid", want.read_valid, seen.read_valid);
               report_field("read_data", want.read_data, seen.read_data);
               report_field("port_write", want.port_write, seen.port_write);
               report_field("port_index", want.port_index, seen.port_index);
               report_field("port_value", want.port_value, seen.port_value);
               report_field("echo_captured", want.echo_captured, seen.echo_captured);
               report_field("echo_length", want.echo_length, seen.echo_length);
            end
         end
         if (req_valid && req_ready)
            expected_replies.push_back(predict_reply(req_kind, req_bus_address,
                                                     req_write_data));
      end
      replies_pending = expected_replies.size();
   end

endmodule

[dv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cte_pkg::*;

   localparam int       CYCLE_LIMIT = 1_000_000;
   localparam int       PHASE_ITEMS = 100;
   localparam int       PHASES = 8;
   localparam int       TAIL_CYCLES = 20;
   localparam kind_type KIND_ERROR = 3'd4;
   localparam kind_type KIND_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = KIND_STOP;
   logic [6:0]  req_bus_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ack;
   logic        rsp_read_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_port_write;
   logic [1:0]  rsp_port_index;
   logic [15:0] rsp_port_value;
   logic        rsp_echo_captured;
   logic [5:0]  rsp_echo_length;
   logic        csr_write_enable = 1'b0;
   logic [6:0]  csr_write_data = '0;

   int         mismatch_count;
   int         replies_pending;
   int         cycle_count = 0;
   int         items_sent = 0;
   bit         request_held = 1'b0;
   bit         no_idling = 1'b0;
   logic [6:0] target_address = OWN_ADDRESS_RESET;

   always #5 clock = ~clock;

   i2c_target_echo_and_port_writer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_bus_address   (req_bus_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ack           (rsp_ack),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_port_write    (rsp_port_write),
      .rsp_port_index    (rsp_port_index),
      .rsp_port_value    (rsp_port_value),
      .rsp_echo_captured (rsp_echo_captured),
      .rsp_echo_length   (rsp_echo_length),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   i2c_reply_checker u_reply_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_bus_address   (req_bus_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ack           (rsp_ack),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_port_write    (rsp_port_write),
      .rsp_port_index    (rsp_port_index),
      .rsp_port_value    (rsp_port_value),
      .rsp_echo_captured (rsp_echo_captured),
      .rsp_echo_length   (rsp_echo_length),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .replies_pending   (replies_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Mostly back to back or short gaps, with the odd long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idling || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [6:0] pick_address();
      if ($urandom_range(0, 4) != 0) return target_address;
      return 7'($urandom_range(0, 127));
   endfunction

   initial begin
      int stall;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic idle_request();
      if (request_held) begin
         req_valid <= 1'b0;
         request_held = 1'b0;
      end
   endtask

   // Valid is left high after an item is taken, so that a following item with no gap
   // goes out without a bubble; anything that lets time pass lowers it first.
   task automatic send_event(kind_type kind, logic [6:0] addr, logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         idle_request();
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_bus_address <= addr;
      req_write_data <= data;
      request_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_for_replies();
      idle_request();
      do @(negedge clock); while (replies_pending != 0);
      @(posedge clock);
   endtask

   task automatic set_own_address(logic [6:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      target_address = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_port_write();
      int len;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : PORT_MSG_LEN;
      send_event(KIND_ADDRESSED, pick_address(), 8'($urandom));
      for (int i = 0; i < len; i++) begin
         if (i == 0 && $urandom_range(0, 3) != 0)
            send_event(KIND_WRITE, 7'($urandom), 8'($urandom_range(0, PORT_COUNT - 1)));
         else
            send_event(KIND_WRITE, 7'($urandom), 8'($urandom));
      end
      send_event(KIND_STOP, 7'($urandom), 8'($urandom));
   endtask

   // Write, repeated start, read back. Now and then the store is overfilled, the
   // second half is another write, or the reads are left out.
   task automatic send_echo();
      int n;
      int reads;
      int variant;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(STORE_DEPTH - 3, STORE_DEPTH + 3)
                                      : $urandom_range(1, 8);
      variant = $urandom_range(0, 9);
      send_event(KIND_ADDRESSED, pick_address(), 8'($urandom));
      repeat (n) send_event(KIND_WRITE, 7'($urandom), 8'($urandom));
      send_event(KIND_ADDRESSED, pick_address(), 8'($urandom));
      if (variant == 0) begin
         repeat ($urandom_range(1, 3)) send_event(KIND_WRITE, 7'($urandom), 8'($urandom));
      end else if (variant != 1) begin
         reads = $urandom_range((n > 1) ? n - 1 : 0, n + 2);
         repeat (reads) send_event(KIND_READ, 7'($urandom), 8'($urandom));
      end
      send_event(KIND_STOP, 7'($urandom), 8'($urandom));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send_event(kind_type'($urandom_range(0, 7)), 7'($urandom), 8'($urandom));
   endtask

   initial begin
      int r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Port write to the last port with all ones.
      send_event(KIND_ADDRESSED, OWN_ADDRESS_RESET, 8'h00);
      send_event(KIND_WRITE, 7'd0, 8'h03);
      send_event(KIND_WRITE, 7'd0, 8'hFF);
      send_event(KIND_WRITE, 7'd0, 8'hFF);
      send_event(KIND_STOP, 7'd0, 8'h00);
      // Echo through a mismatched repeated start, reading one byte past the data.
      send_event(KIND_ADDRESSED, OWN_ADDRESS_RESET, 8'h00);
      send_event(KIND_WRITE, 7'd127, 8'h00);
      send_event(KIND_WRITE, 7'd0, 8'hFF);
      send_event(KIND_ADDRESSED, 7'd127, 8'hFF);
      send_event(KIND_READ, 7'd0, 8'h00);
      send_event(KIND_READ, 7'd0, 8'h00);
      send_event(KIND_READ, 7'd0, 8'h00);
      send_event(KIND_STOP, 7'd0, 8'h00);
      // A port selector out of range.
      send_event(KIND_ADDRESSED, 7'd0, 8'h00);
      send_event(KIND_WRITE, 7'd0, 8'h04);
      send_event(KIND_WRITE, 7'd0, 8'h12);
      send_event(KIND_WRITE, 7'd0, 8'h34);
      send_event(KIND_STOP, 7'd0, 8'h00);
      // Write, then write again after a repeated start: nothing is reported.
      send_event(KIND_WRITE, 7'd0, 8'h55);
      send_event(KIND_ADDRESSED, OWN_ADDRESS_RESET, 8'h00);
      send_event(KIND_WRITE, 7'd0, 8'hAA);
      send_event(KIND_STOP, 7'd0, 8'h00);
      send_event(KIND_ERROR, 7'd127, 8'hFF);
      send_event(KIND_UNUSED, 7'd127, 8'hFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         // The sender holds off here until the block has answered everything.
         wait_for_replies();
         case (phase)
            0:          set_own_address(7'd127);
            1:          set_own_address(7'd0);
            PHASES - 1: set_own_address(OWN_ADDRESS_RESET);
            default:    set_own_address(7'($urandom_range(0, 127)));
         endcase
         no_idling = (phase == 3);
         while (items_sent < (phase + 1) * PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) send_port_write();
            else if (r < 80) send_echo();
            else send_noise();
         end
      end
      no_idling = 1'b0;

      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && replies_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/i2cte_pkg.sv
rtl/core/i2cte_ram.sv
rtl/core/i2cte_seq.sv
rtl/core/i2c_target_echo_and_port_writer.sv
dv/i2c_reply_checker.sv
dv/tb_top.sv
